[hw/rtl/lz4d_pkg.sv]
// Shared types and constants for the LZ4 block decoder.
// No dependencies; used by lz4_block_decoder, lz4d_front and lz4d_back under hw/rtl.
package lz4d_pkg;

	localparam int HISTORY_DEPTH = 65536;
	localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
	localparam int CNT_W         = 25;
	localparam int CMD_DEPTH     = 4;
	localparam int RES_DEPTH     = 4;

	localparam logic [CNT_W-1:0] LEN_CAP = CNT_W'(1 << 24);

	// request codes
	localparam logic [1:0] FN_BYTE  = 2'd0;
	localparam logic [1:0] FN_PUMP  = 2'd1;
	localparam logic [1:0] FN_START = 2'd2;

	// run status codes
	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	// config register indexes
	localparam logic [1:0] REG_INPUT_LENGTH    = 2'd0;
	localparam logic [1:0] REG_OUTPUT_CAPACITY = 2'd1;

	typedef enum logic [6:0] {
		PH_TOKEN   = 7'b0000001,
		PH_LITEXT  = 7'b0000010,
		PH_LITERAL = 7'b0000100,
		PH_OFFLO   = 7'b0001000,
		PH_OFFHI   = 7'b0010000,
		PH_MATEXT  = 7'b0100000,
		PH_MATCH   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] in_byte;
	} item_t;

	typedef struct packed {
		logic             out_valid;
		logic [7:0]       out_byte;
		logic             consumed;
		logic [1:0]       status;
		logic [CNT_W-1:0] produced_count;
	} result_t;

	// front-to-back command: one per accepted item
	typedef struct packed {
		logic               we;
		logic               is_copy;
		logic [7:0]         lit;
		logic [HIST_AW-1:0] wa;
		logic [HIST_AW-1:0] ra;
		logic               consumed;
		logic [1:0]         status;
		logic [CNT_W-1:0]   produced_count;
	} cmd_t;

endpackage

[hw/rtl/lz4_block_decoder.sv]
// LZ4 block decoder top: parser front, command queue, history back end, result queue.
// A result passes the command queue, the back-end stage 2 registers and the result queue.
// Throughput: one item per cycle while no queue is full, set by one history read and write.
// A match byte one back is forwarded, so overlapping copies keep full rate.
// Reset (arst_n low, async) clears parser state, config registers and both queues;
// history contents are undefined until written.
module lz4_block_decoder #(
	parameter int CMD_DEPTH = lz4d_pkg::CMD_DEPTH,
	parameter int RES_DEPTH = lz4d_pkg::RES_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  lz4d_pkg::item_t            item,
	output logic                       full,
	output logic                       empty,
	input  logic                       pop,
	output lz4d_pkg::result_t          result,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [lz4d_pkg::CNT_W-1:0] cfg_data
);

	localparam int CMD_W = $bits(lz4d_pkg::cmd_t);
	localparam int RES_W = $bits(lz4d_pkg::result_t);

	lz4d_pkg::cmd_t                 cmd_in, cmd_out;
	lz4d_pkg::result_t              res_in;
	logic                           accept, cmd_empty, cmd_pop, res_push, res_full;
	logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
	logic [$clog2(RES_DEPTH+1)-1:0] res_count;

	assign accept = push && !full;

	lz4d_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .item(item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd_in)
	);

	// command queue between front and back
	lz4d_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
		.clk(clk), .arst_n(arst_n), .push(accept), .din(cmd_in), .full(full),
		.pop(cmd_pop), .dout(cmd_out), .empty(cmd_empty), .count(cmd_count)
	);

	lz4d_back #(.RES_DEPTH(RES_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_out), .cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop), .res_count(res_count), .res_push(res_push), .res(res_in)
	);

	// result queue
	lz4d_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_q (
		.clk(clk), .arst_n(arst_n), .push(res_push), .din(res_in), .full(res_full),
		.pop(pop), .dout(result), .empty(empty), .count(res_count)
	);

	// back end credit must never overrun the result queue
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && res_full))
		else $error("result queue overflow");

	// a decoded byte always counts toward produced output
	a_valid_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.out_valid) |-> (result.produced_count != '0))
		else $error("decoded byte with zero produced count");

	// an accepted item always lands in the command queue
	a_cmd_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (cmd_count != '0))
		else $error("accepted item missing from command queue");

endmodule

[hw/rtl/lz4d_fifo.sv]
// Small counter-based FIFO for the command and result queues.
// No package dependency.
module lz4d_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (do_pop)  rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[hw/rtl/lz4d_front.sv]
// Front end: token/length/offset parser, checks and config registers.
// Depends on lz4d_pkg; emits one lz4d_pkg::cmd_t per accepted item.
module lz4d_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  lz4d_pkg::item_t             item,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [lz4d_pkg::CNT_W-1:0]  cfg_data,
	output lz4d_pkg::cmd_t              cmd
);

	localparam int W = lz4d_pkg::CNT_W;

	lz4d_pkg::phase_t phase_q;
	logic [W-1:0]     lit_q, mat_q, br_q, bw_q, in_len_q, out_cap_q;
	logic [3:0]       nib_q;
	logic [15:0]      off_q;
	logic [1:0]       st_q;

	lz4d_pkg::phase_t ph;
	logic [W-1:0]     lit, mat, br, bw, bwr;
	logic [3:0]       nib;
	logic [15:0]      off;
	logic [1:0]       st;
	logic             valid, copy, took;
	logic [7:0]       b;

	function automatic logic [W-1:0] left(input logic [W-1:0] used, input logic [W-1:0] lim);
		return (used >= lim) ? '0 : lim - used;
	endfunction

	function automatic logic [1:0] settle(input logic [1:0] s, input lz4d_pkg::phase_t p,
			input logic [W-1:0] il);
		logic [1:0] r;
		r = s;
		if (s == lz4d_pkg::ST_RUN) begin
			unique case (p)
				lz4d_pkg::PH_TOKEN:   if (il == '0) r = lz4d_pkg::ST_DONE;
				lz4d_pkg::PH_LITEXT,
				lz4d_pkg::PH_LITERAL,
				lz4d_pkg::PH_OFFHI,
				lz4d_pkg::PH_MATEXT:  if (il == '0) r = lz4d_pkg::ST_ERR;
				lz4d_pkg::PH_OFFLO:   if (il < W'(2)) r = lz4d_pkg::ST_ERR;
				default: ;
			endcase
		end
		return r;
	endfunction

	// one decode step
	always_comb begin
		ph = phase_q; lit = lit_q; mat = mat_q; nib = nib_q; off = off_q;
		br = br_q; bw = bw_q; st = st_q;
		valid = 1'b0; copy = 1'b0; took = 1'b0;
		bwr = bw_q;
		b = item.in_byte;
		if (item.func == lz4d_pkg::FN_START) begin
			ph = lz4d_pkg::PH_TOKEN; lit = '0; mat = '0; nib = '0; off = '0;
			br = '0; bw = '0; st = lz4d_pkg::ST_RUN;
		end
		bwr = bw;
		st = settle(st, ph, left(br, in_len_q));

		if (st == lz4d_pkg::ST_RUN && item.func == lz4d_pkg::FN_BYTE &&
				ph != lz4d_pkg::PH_MATCH) begin
			took = 1'b1;
			br = br + 1'b1;
			unique case (ph)
				lz4d_pkg::PH_TOKEN: begin
					nib = b[3:0];
					lit = W'(b[7:4]);
					if (lit == W'(15)) ph = lz4d_pkg::PH_LITEXT;
					else if (lit > left(br, in_len_q) || lit > left(bw, out_cap_q))
						st = lz4d_pkg::ST_ERR;
					else if (lit == '0) begin
						ph = lz4d_pkg::PH_TOKEN;
						if (left(br, in_len_q) == '0 || left(bw, out_cap_q) == '0)
							st = lz4d_pkg::ST_DONE;
						else ph = lz4d_pkg::PH_OFFLO;
					end else ph = lz4d_pkg::PH_LITERAL;
				end
				lz4d_pkg::PH_LITEXT: begin
					if (lit - W'(15) > lz4d_pkg::LEN_CAP) st = lz4d_pkg::ST_ERR;
					else begin
						lit = lit + W'(b);
						if (b != 8'd255) begin
							if (lit > left(br, in_len_q) || lit > left(bw, out_cap_q))
								st = lz4d_pkg::ST_ERR;
							else if (lit == '0) begin
								ph = lz4d_pkg::PH_TOKEN;
								if (left(br, in_len_q) == '0 || left(bw, out_cap_q) == '0)
									st = lz4d_pkg::ST_DONE;
								else ph = lz4d_pkg::PH_OFFLO;
							end else ph = lz4d_pkg::PH_LITERAL;
						end
					end
				end
				lz4d_pkg::PH_LITERAL: begin
					valid = 1'b1;
					bw = bw + 1'b1;
					lit = lit - 1'b1;
					if (lit == '0) begin
						ph = lz4d_pkg::PH_TOKEN;
						if (left(br, in_len_q) == '0 || left(bw, out_cap_q) == '0)
							st = lz4d_pkg::ST_DONE;
						else ph = lz4d_pkg::PH_OFFLO;
					end
				end
				lz4d_pkg::PH_OFFLO: begin
					off = {8'd0, b};
					ph = lz4d_pkg::PH_OFFHI;
				end
				lz4d_pkg::PH_OFFHI: begin
					off = {b, off[7:0]};
					if (off == '0 || W'(off) > bw) st = lz4d_pkg::ST_ERR;
					else if (nib == 4'd15) begin
						mat = W'(15);
						ph = lz4d_pkg::PH_MATEXT;
					end else begin
						mat = W'(nib) + W'(4);
						if (mat > left(bw, out_cap_q)) st = lz4d_pkg::ST_ERR;
						else ph = lz4d_pkg::PH_MATCH;
					end
				end
				lz4d_pkg::PH_MATEXT: begin
					if (mat - W'(15) > lz4d_pkg::LEN_CAP) st = lz4d_pkg::ST_ERR;
					else begin
						mat = mat + W'(b);
						if (b != 8'd255) begin
							mat = mat + W'(4);
							if (mat > left(bw, out_cap_q)) st = lz4d_pkg::ST_ERR;
							else ph = lz4d_pkg::PH_MATCH;
						end
					end
				end
				default: begin
					took = 1'b0;
					br = br - 1'b1;
				end
			endcase
		end else if (st == lz4d_pkg::ST_RUN && item.func == lz4d_pkg::FN_PUMP &&
				ph == lz4d_pkg::PH_MATCH) begin
			valid = 1'b1;
			copy = 1'b1;
			bw = bw + 1'b1;
			mat = mat - 1'b1;
			if (mat == '0) ph = lz4d_pkg::PH_TOKEN;
		end

		st = settle(st, ph, left(br, in_len_q));

		cmd.we             = valid;
		cmd.is_copy        = copy;
		cmd.lit            = b;
		cmd.wa             = bwr[lz4d_pkg::HIST_AW-1:0];
		cmd.ra             = bwr[lz4d_pkg::HIST_AW-1:0] - off_q[lz4d_pkg::HIST_AW-1:0];
		cmd.consumed       = took;
		cmd.status         = st;
		cmd.produced_count = bw;
	end

	// parser state and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lz4d_pkg::PH_TOKEN;
			lit_q     <= '0;
			mat_q     <= '0;
			nib_q     <= '0;
			off_q     <= '0;
			br_q      <= '0;
			bw_q      <= '0;
			st_q      <= lz4d_pkg::ST_RUN;
			in_len_q  <= '0;
			out_cap_q <= '0;
		end else begin
			if (accept) begin
				phase_q <= ph;
				lit_q   <= lit;
				mat_q   <= mat;
				nib_q   <= nib;
				off_q   <= off;
				br_q    <= br;
				bw_q    <= bw;
				st_q    <= st;
			end
			if (cfg_we) begin
				if (cfg_index == lz4d_pkg::REG_INPUT_LENGTH)    in_len_q  <= cfg_data;
				if (cfg_index == lz4d_pkg::REG_OUTPUT_CAPACITY) out_cap_q <= cfg_data;
			end
		end
	end

endmodule

[hw/rtl/lz4d_back.sv]
// Back end: 64 KiB history ring, registered read with one-back forwarding.
// Depends on lz4d_pkg; pops lz4d_pkg::cmd_t, pushes lz4d_pkg::result_t.
module lz4d_back #(
	parameter int RES_DEPTH = lz4d_pkg::RES_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lz4d_pkg::cmd_t                 cmd,
	input  logic                           cmd_empty,
	output logic                           cmd_pop,
	input  logic [$clog2(RES_DEPTH+1)-1:0] res_count,
	output logic                           res_push,
	output lz4d_pkg::result_t              res
);

	localparam int CW = $clog2(RES_DEPTH+1);

	logic [7:0]     hist_q [lz4d_pkg::HISTORY_DEPTH];
	logic [7:0]     rdata_q;
	logic           v_s2, hit_s2;
	logic [7:0]     fwd_s2;
	lz4d_pkg::cmd_t cmd_s2;
	logic [7:0]     byte_s2;
	logic           hit;

	// pop only when the result queue has room for everything in flight
	assign cmd_pop = !cmd_empty &&
		((CW+1)'(res_count) + (CW+1)'(v_s2) < (CW+1)'(RES_DEPTH));

	// previous copy/literal is written at the same edge this read happens
	assign hit = v_s2 && cmd_s2.we && (cmd_s2.wa == cmd.ra);

	assign byte_s2 = cmd_s2.is_copy ? (hit_s2 ? fwd_s2 : rdata_q) : cmd_s2.lit;

	// history ring
	always_ff @(posedge clk) begin
		if (v_s2 && cmd_s2.we) hist_q[cmd_s2.wa] <= byte_s2;
		if (cmd_pop) rdata_q <= hist_q[cmd.ra];
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= cmd_pop;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s2 <= cmd;
			hit_s2 <= hit;
			fwd_s2 <= byte_s2;
		end
	end

	// result formatting
	assign res_push           = v_s2;
	assign res.out_valid      = cmd_s2.we;
	assign res.out_byte       = cmd_s2.we ? byte_s2 : 8'd0;
	assign res.consumed       = cmd_s2.consumed;
	assign res.status         = cmd_s2.status;
	assign res.produced_count = cmd_s2.produced_count;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for lz4_block_decoder: a scoreboard class predicts every result.
// Depends on lz4d_pkg (item/result structs, request and status codes) and the decoder RTL.
module tb;

	localparam int unsigned CNT_MASK  = 32'h1FF_FFFF;
	localparam int unsigned MAX_LEN   = 32'h100_0000;
	localparam int unsigned CYC_LIMIT = 1_500_000;
	localparam logic [1:0]  FN_NONE   = 2'd3;

	// Predicts the decoder result for every accepted item and checks results in order.
	class decode_scoreboard;
		lz4d_pkg::result_t want_q[$];
		int                fails;
		lz4d_pkg::phase_t  ph;
		int unsigned       lit_left, mat_left, rd, wr, in_len, out_cap;
		logic [3:0]        nib;
		logic [15:0]       off;
		logic [1:0]        st;
		logic [7:0]        hist [lz4d_pkg::HISTORY_DEPTH];

		function new();
			fails = 0;
			in_len = 0;
			out_cap = 0;
			clear_block();
		endfunction

		function void clear_block();
			ph = lz4d_pkg::PH_TOKEN;
			lit_left = 0;
			mat_left = 0;
			nib = '0;
			off = '0;
			rd = 0;
			wr = 0;
			st = lz4d_pkg::ST_RUN;
		endfunction

		function void set_reg(logic [1:0] idx, int unsigned val);
			if (idx == lz4d_pkg::REG_INPUT_LENGTH) in_len = val & CNT_MASK;
			else if (idx == lz4d_pkg::REG_OUTPUT_CAPACITY) out_cap = val & CNT_MASK;
		endfunction

		function int unsigned in_left();
			return (rd >= in_len) ? 0 : in_len - rd;
		endfunction

		function int unsigned out_left();
			return (wr >= out_cap) ? 0 : out_cap - wr;
		endfunction

		// end-of-input checks applied before and after each transfer
		function void settle();
			if (st != lz4d_pkg::ST_RUN) return;
			case (ph)
				lz4d_pkg::PH_TOKEN: if (in_left() == 0) st = lz4d_pkg::ST_DONE;
				lz4d_pkg::PH_LITEXT, lz4d_pkg::PH_LITERAL, lz4d_pkg::PH_OFFHI,
				lz4d_pkg::PH_MATEXT: if (in_left() == 0) st = lz4d_pkg::ST_ERR;
				lz4d_pkg::PH_OFFLO: if (in_left() < 2) st = lz4d_pkg::ST_ERR;
				default: ;
			endcase
		endfunction

		function void after_lits();
			ph = lz4d_pkg::PH_TOKEN;
			if (in_left() == 0 || out_left() == 0) st = lz4d_pkg::ST_DONE;
			else ph = lz4d_pkg::PH_OFFLO;
		endfunction

		function void lits_known();
			if (lit_left > in_left() || lit_left > out_left()) st = lz4d_pkg::ST_ERR;
			else if (lit_left == 0) after_lits();
			else ph = lz4d_pkg::PH_LITERAL;
		endfunction

		function void match_known();
			mat_left += 4;
			if (mat_left > out_left()) st = lz4d_pkg::ST_ERR;
			else ph = lz4d_pkg::PH_MATCH;
		endfunction

		function void emit(logic [7:0] b);
			hist[wr[15:0]] = b;
			wr = (wr + 1) & CNT_MASK;
		endfunction

		function lz4d_pkg::result_t decode(lz4d_pkg::item_t it);
			lz4d_pkg::result_t r;
			logic [7:0]        b;
			r = '0;
			b = it.in_byte;
			if (it.func == lz4d_pkg::FN_START) clear_block();
			settle();
			if (st == lz4d_pkg::ST_RUN && it.func == lz4d_pkg::FN_BYTE &&
					ph != lz4d_pkg::PH_MATCH) begin
				r.consumed = 1'b1;
				rd = (rd + 1) & CNT_MASK;
				case (ph)
					lz4d_pkg::PH_TOKEN: begin
						nib = b[3:0];
						lit_left = 32'(b[7:4]);
						if (lit_left == 15) ph = lz4d_pkg::PH_LITEXT;
						else lits_known();
					end
					lz4d_pkg::PH_LITEXT: begin
						if (lit_left - 15 > lz4d_pkg::LEN_CAP) st = lz4d_pkg::ST_ERR;
						else begin
							lit_left += 32'(b);
							if (b != 8'hFF) lits_known();
						end
					end
					lz4d_pkg::PH_LITERAL: begin
						r.out_valid = 1'b1;
						r.out_byte = b;
						emit(b);
						lit_left--;
						if (lit_left == 0) after_lits();
					end
					lz4d_pkg::PH_OFFLO: begin
						off = {8'h00, b};
						ph = lz4d_pkg::PH_OFFHI;
					end
					lz4d_pkg::PH_OFFHI: begin
						off[15:8] = b;
						if (off == 0 || 32'(off) > wr) st = lz4d_pkg::ST_ERR;
						else if (nib == 4'hF) begin
							mat_left = 15;
							ph = lz4d_pkg::PH_MATEXT;
						end else begin
							mat_left = 32'(nib);
							match_known();
						end
					end
					lz4d_pkg::PH_MATEXT: begin
						if (mat_left - 15 > lz4d_pkg::LEN_CAP) st = lz4d_pkg::ST_ERR;
						else begin
							mat_left += 32'(b);
							if (b != 8'hFF) match_known();
						end
					end
					default: ;
				endcase
			end else if (st == lz4d_pkg::ST_RUN && it.func == lz4d_pkg::FN_PUMP &&
					ph == lz4d_pkg::PH_MATCH) begin
				r.out_valid = 1'b1;
				r.out_byte = hist[16'(wr - 32'(off))];
				emit(r.out_byte);
				mat_left--;
				if (mat_left == 0) ph = lz4d_pkg::PH_TOKEN;
			end
			settle();
			r.status = st;
			r.produced_count = wr[lz4d_pkg::CNT_W-1:0];
			return r;
		endfunction

		function void note_item(lz4d_pkg::item_t it);
			want_q.push_back(decode(it));
		endfunction

		function void report(string field, longint want, longint got);
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
			fails++;
		endfunction

		function void check_result(lz4d_pkg::result_t got);
			lz4d_pkg::result_t w;
			if (want_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				fails++;
				return;
			end
			w = want_q.pop_front();
			if (got.out_valid !== w.out_valid) report("out_valid", w.out_valid, got.out_valid);
			if (got.out_byte !== w.out_byte) report("out_byte", w.out_byte, got.out_byte);
			if (got.consumed !== w.consumed) report("consumed", w.consumed, got.consumed);
			if (got.status !== w.status) report("status", w.status, got.status);
			if (got.produced_count !== w.produced_count)
				report("produced_count", w.produced_count, got.produced_count);
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       push = 1'b0;
	lz4d_pkg::item_t            item = '0;
	logic                       full, empty;
	logic                       pop = 1'b0;
	lz4d_pkg::result_t          result;
	logic                       cfg_we = 1'b0;
	logic [1:0]                 cfg_index = '0;
	logic [lz4d_pkg::CNT_W-1:0] cfg_data = '0;

	decode_scoreboard sb = new();
	int unsigned      cyc = 0;
	int               sent = 0;
	int               hold_off = 0;
	bit               calm = 1'b0;

	lz4_block_decoder DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .item(item), .full(full),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// transfer monitors and run limit
	always @(posedge clk) begin
		cyc++;
		if (arst_n && push && !full) sb.note_item(item);
		if (arst_n && pop && !empty) sb.check_result(result);
		if (cyc > CYC_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side: random stalls plus a long hold-off on request
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				hold_off--;
				pop <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall = gap_len();
			end
		end
	end

	function automatic lz4d_pkg::item_t mk(logic [1:0] f, logic [7:0] b);
		lz4d_pkg::item_t it;
		it.func = f;
		it.in_byte = b;
		return it;
	endfunction

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic offer(lz4d_pkg::item_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		if (it.func != FN_NONE) sent++;
	endtask

	// drain everything, then let the pipeline settle before touching registers
	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (sb.want_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[lz4d_pkg::CNT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic run_block(lz4d_pkg::item_t q[$], int unsigned in_len, int unsigned cap);
		wait_idle();
		write_reg(lz4d_pkg::REG_INPUT_LENGTH, in_len);
		write_reg(lz4d_pkg::REG_OUTPUT_CAPACITY, cap);
		offer(mk(lz4d_pkg::FN_START, rnd_byte()));
		foreach (q[i]) offer(q[i]);
	endtask

	// extension bytes for a length of 15 or more
	function automatic void put_ext(ref lz4d_pkg::item_t q[$], input int unsigned extra);
		while (extra >= 255) begin
			q.push_back(mk(lz4d_pkg::FN_BYTE, 8'hFF));
			extra -= 255;
		end
		q.push_back(mk(lz4d_pkg::FN_BYTE, extra[7:0]));
	endfunction

	// block of literal and match sequences ending in literals; noisy adds stray requests in copies
	function automatic void build(ref lz4d_pkg::item_t q[$], output int unsigned nbytes,
			output int unsigned nout, input int nseq, int lmin, int lmax,
			int mmin, int mmax, bit noisy);
		int unsigned lit, m, o, hi;
		nout = 0;
		for (int s = 0; s < nseq; s++) begin
			lit = $urandom_range(lmin, lmax);
			if (nout == 0 && s != nseq - 1 && lit == 0) lit = 1;
			m = $urandom_range(mmin, mmax);
			q.push_back(mk(lz4d_pkg::FN_BYTE,
				{4'((lit >= 15) ? 15 : lit), 4'((m >= 15) ? 15 : m)}));
			if (lit >= 15) put_ext(q, lit - 15);
			repeat (lit) q.push_back(mk(lz4d_pkg::FN_BYTE, rnd_byte()));
			nout += lit;
			if (s == nseq - 1) break;
			hi = (nout > 65535) ? 65535 : nout;
			o = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, hi);
			q.push_back(mk(lz4d_pkg::FN_BYTE, o[7:0]));
			q.push_back(mk(lz4d_pkg::FN_BYTE, o[15:8]));
			if (m >= 15) put_ext(q, m - 15);
			for (int p = 0; p < m + 4; p++) begin
				q.push_back(mk(lz4d_pkg::FN_PUMP, rnd_byte()));
				if (noisy && p < m + 3 && $urandom_range(0, 9) == 0)
					q.push_back(mk(lz4d_pkg::FN_BYTE, rnd_byte()));
				if (noisy && $urandom_range(0, 19) == 0)
					q.push_back(mk(FN_NONE, rnd_byte()));
			end
			nout += m + 4;
		end
		nbytes = 0;
		foreach (q[i]) if (q[i].func == lz4d_pkg::FN_BYTE) nbytes++;
		if (noisy) nbytes = nbytes;
	endfunction

	initial begin
		lz4d_pkg::item_t q[$];
		int unsigned     nb, no, cap, len, r;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// zero-length block finishes at once; the offered byte stays unread
		run_block('{mk(lz4d_pkg::FN_BYTE, 8'h10), mk(lz4d_pkg::FN_PUMP, 8'h00)}, 0, 0);
		// output capacity zero with a literal: error, then ignored pump
		run_block('{mk(lz4d_pkg::FN_BYTE, 8'h10), mk(lz4d_pkg::FN_PUMP, 8'h00)}, 5, 0);
		// zero offset and an offset past the output are both errors
		run_block('{mk(lz4d_pkg::FN_BYTE, 8'h14), mk(lz4d_pkg::FN_BYTE, 8'hA5),
			mk(lz4d_pkg::FN_BYTE, 8'h00), mk(lz4d_pkg::FN_BYTE, 8'h00)}, 8, 100);
		run_block('{mk(lz4d_pkg::FN_BYTE, 8'h14), mk(lz4d_pkg::FN_BYTE, 8'h5A),
			mk(lz4d_pkg::FN_BYTE, 8'h02), mk(lz4d_pkg::FN_BYTE, 8'h00)}, 8, 100);
		// fewer than two offset bytes left
		run_block('{mk(lz4d_pkg::FN_BYTE, 8'h10), mk(lz4d_pkg::FN_BYTE, 8'hFF),
			mk(lz4d_pkg::FN_BYTE, 8'h01)}, 3, 10);
		// wrong requests: unknown func, pump at a token, byte during a copy, start mid-copy
		run_block('{mk(FN_NONE, 8'hFF), mk(lz4d_pkg::FN_PUMP, 8'h33),
			mk(lz4d_pkg::FN_BYTE, 8'h10), mk(lz4d_pkg::FN_BYTE, 8'h7E),
			mk(lz4d_pkg::FN_BYTE, 8'h01), mk(lz4d_pkg::FN_BYTE, 8'h00),
			mk(lz4d_pkg::FN_PUMP, 8'h00), mk(lz4d_pkg::FN_BYTE, 8'hC3),
			mk(lz4d_pkg::FN_PUMP, 8'h00), mk(lz4d_pkg::FN_START, 8'h00),
			mk(lz4d_pkg::FN_BYTE, 8'h00)}, 6, 20);
		// literal length continued by a 255 byte, longer than the input left
		run_block('{mk(lz4d_pkg::FN_BYTE, 8'hF0), mk(lz4d_pkg::FN_BYTE, 8'hFF),
			mk(lz4d_pkg::FN_BYTE, 8'h00)}, 10, 1000);
		// match length continued by a 255 byte, longer than the output left
		run_block('{mk(lz4d_pkg::FN_BYTE, 8'h1F), mk(lz4d_pkg::FN_BYTE, 8'h42),
			mk(lz4d_pkg::FN_BYTE, 8'h01), mk(lz4d_pkg::FN_BYTE, 8'h00),
			mk(lz4d_pkg::FN_BYTE, 8'hFF), mk(lz4d_pkg::FN_BYTE, 8'h00)}, 20, 10);
		calm = 1'b0;
		sent = 0;

		// random blocks; the first one runs against a long receiver stall
		while (sent < 650) begin
			q = {};
			r = $urandom_range(0, 99);
			if (r < 80) begin
				if ($urandom_range(0, 4) == 0)
					build(q, nb, no, $urandom_range(1, 4), 0, 40, 0, 40, 1'b1);
				else
					build(q, nb, no, $urandom_range(1, 4), 0, 8, 0, 10, 1'b1);
				r = $urandom_range(0, 99);
				len = nb;
				if (r < 15) begin
					repeat ($urandom_range(1, 4)) q.push_back(mk(lz4d_pkg::FN_BYTE, rnd_byte()));
					len = nb + $urandom_range(1, 4);
				end else if (r < 25 && nb > 0) len = nb - $urandom_range(1, nb);
				r = $urandom_range(0, 99);
				if (r < 60) cap = no;
				else if (r < 80) cap = no + $urandom_range(0, 50);
				else if (r < 90 && no > 0) cap = no - $urandom_range(1, (no < 5) ? no : 5);
				else cap = MAX_LEN;
			end else begin
				repeat ($urandom_range(5, 30))
					q.push_back(mk(2'($urandom_range(0, 3)), rnd_byte()));
				len = $urandom_range(0, 20);
				cap = $urandom_range(0, 20);
			end
			calm = ($urandom_range(0, 5) == 0);
			if (hold_off == 0 && sent == 0) begin
				calm = 1'b1;
				q = {};
				build(q, nb, no, 4, 10, 20, 10, 20, 1'b0);
				len = nb;
				cap = no;
				hold_off = 300;
			end
			run_block(q, len, cap);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (sb.fails == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

[sim.f]
hw/rtl/lz4d_pkg.sv
hw/rtl/lz4d_fifo.sv
hw/rtl/lz4d_front.sv
hw/rtl/lz4d_back.sv
hw/rtl/lz4_block_decoder.sv
tb/sv/tb.sv
